### hdl/fpbr_pkg.sv
// Shared types, constants and a helper function of the frame pacing buffer rotator.
package fpbr_pkg;

    // Command codes carried by the input tuser bit
    localparam logic CMD_FRAME_END = 1'b0;
    localparam logic CMD_RESTART   = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIPLE_BUFFERING = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOCK_SINGLE      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BUFFER0_ADDRESS  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BUFFER1_ADDRESS  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BUFFER2_ADDRESS  = 3'd4;

    // Pacing constants
    localparam logic [2:0] MAX_INTERVAL     = 3'd4;
    localparam logic [6:0] FAST_LIMIT       = 7'd30;
    localparam logic [2:0] RESTART_INTERVAL = 3'd2;
    localparam logic [2:0] SLOW_DOWN_MIN    = 3'd3;
    localparam logic [2:0] LOCKED_INTERVAL  = 3'd1;
    localparam logic [3:0] WAITED_MAX       = 4'd15;

    // Ring positions
    localparam logic [1:0] RING_FIRST     = 2'd0;
    localparam logic [1:0] RING_LAST      = 2'd2;
    localparam logic [2:0] RING_LEN_TRIPLE = 3'd3;
    localparam logic [2:0] RING_LEN_DOUBLE = 3'd2;

    // Configuration register contents
    typedef struct packed {
        logic        triple;
        logic        lock;
        logic [31:0] addr2;
        logic [31:0] addr1;
        logic [31:0] addr0;
    } fpbr_cfg_t;

    // One input item
    typedef struct packed {
        logic       command;
        logic [3:0] pending;
        logic       skip;
    } fpbr_item_t;

    // Buffer addresses produced by the ring
    typedef struct packed {
        logic [31:0] display;
        logic [31:0] draw;
        logic [31:0] next_draw;
    } fpbr_ring_out_t;

    // Pacing results
    typedef struct packed {
        logic [2:0] target;
        logic [3:0] waited;
    } fpbr_pace_out_t;

    // Control from the pipeline to the state-holding units
    typedef struct packed {
        logic step;
        logic restart;
        logic skip;
    } fpbr_ctrl_t;

    // Address of the buffer at a ring position; the unused position reads as buffer zero.
    function automatic logic [31:0] buffer_at(fpbr_cfg_t cfg, logic [1:0] idx);
        logic [31:0] addr;
        case (idx)
            2'd1:    addr = cfg.addr1;
            2'd2:    addr = cfg.addr2;
            default: addr = cfg.addr0;
        endcase
        return addr;
    endfunction

endpackage

### hdl/fpbr_cfg_regs.sv
// Configuration register file of the frame pacing buffer rotator.
module fpbr_cfg_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    input  logic [fpbr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [31:0]                          cfg_data,
    input  logic                                 lock_clear,
    output fpbr_pkg::fpbr_cfg_t                  cfg
);

    fpbr_pkg::fpbr_cfg_t cfg_reg;
    fpbr_pkg::fpbr_cfg_t cfg_next;

    // Register writes; a restart transaction drops the interval lock.
    always_comb begin
        cfg_next = cfg_reg;
        if (lock_clear) begin
            cfg_next.lock = 1'b0;
        end
        if (cfg_valid) begin
            unique case (cfg_index)
                fpbr_pkg::REG_TRIPLE_BUFFERING: cfg_next.triple = cfg_data[0];
                fpbr_pkg::REG_LOCK_SINGLE:      cfg_next.lock   = cfg_data[0];
                fpbr_pkg::REG_BUFFER0_ADDRESS:  cfg_next.addr0  = cfg_data;
                fpbr_pkg::REG_BUFFER1_ADDRESS:  cfg_next.addr1  = cfg_data;
                fpbr_pkg::REG_BUFFER2_ADDRESS:  cfg_next.addr2  = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/fpbr_ring.sv
// Framebuffer ring: rotation index, shown buffer and draw addresses.
module fpbr_ring (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  fpbr_pkg::fpbr_ctrl_t     ctrl,
    input  fpbr_pkg::fpbr_cfg_t      cfg,
    output fpbr_pkg::fpbr_ring_out_t ring_out
);

    logic [1:0]  ring_index_reg;
    logic [1:0]  ring_index_next;
    logic [31:0] shown_reg;
    logic [31:0] shown_next;
    logic [1:0]  idx_start;
    logic [2:0]  idx_inc;
    logic [2:0]  ring_len;
    logic        rotate;

    // A restart starts the ring at position zero and always rotates once.
    always_comb begin
        idx_start = ctrl.restart ? fpbr_pkg::RING_FIRST : ring_index_reg;
        rotate    = ctrl.restart || !ctrl.skip;
        idx_inc   = {1'b0, idx_start} + 3'd1;
        ring_len  = cfg.triple ? fpbr_pkg::RING_LEN_TRIPLE : fpbr_pkg::RING_LEN_DOUBLE;
        if (rotate) begin
            shown_next      = fpbr_pkg::buffer_at(cfg, idx_start);
            ring_index_next = (idx_inc >= ring_len) ? fpbr_pkg::RING_FIRST : idx_inc[1:0];
        end else begin
            shown_next      = shown_reg;
            ring_index_next = idx_start;
        end
    end

    // Draw addresses follow the updated index and the present configuration.
    always_comb begin
        ring_out.display = shown_next;
        ring_out.draw    = fpbr_pkg::buffer_at(cfg, ring_index_next);
        if (!cfg.triple) begin
            ring_out.next_draw = ring_out.draw;
        end else if (ring_index_next < fpbr_pkg::RING_LAST) begin
            ring_out.next_draw = fpbr_pkg::buffer_at(cfg, ring_index_next + 2'd1);
        end else begin
            ring_out.next_draw = cfg.addr0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_index_reg <= fpbr_pkg::RING_FIRST;
            shown_reg      <= '0;
        end else if (ctrl.step) begin
            ring_index_reg <= ring_index_next;
            shown_reg      <= shown_next;
        end
    end

`ifndef SYNTHESIS
    // The fourth ring position is never entered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ring_index_reg != 2'd3)
        else $error("ring index reached the unused position");
`endif

endmodule

### hdl/fpbr_pace.sv
// Swap interval adaptation from the count of pending vblanks.
module fpbr_pace (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  fpbr_pkg::fpbr_ctrl_t     ctrl,
    input  logic [3:0]               pending,
    input  logic                     lock,
    output fpbr_pkg::fpbr_pace_out_t pace_out
);

    logic       first_frame_reg;
    logic       first_frame_next;
    logic [5:0] fast_acc_reg;
    logic [5:0] fast_acc_next;
    logic [2:0] target_reg;
    logic [2:0] target_next;
    logic [4:0] rate;
    logic [6:0] fast_sum;
    logic [4:0] waited_full;

    // Adaptation of the target interval, then the lock and the waited count.
    always_comb begin
        first_frame_next = first_frame_reg;
        fast_acc_next    = fast_acc_reg;
        target_next      = target_reg;
        rate             = {1'b0, pending} + 5'd1;
        fast_sum         = {1'b0, fast_acc_reg} + {2'b00, rate};
        waited_full      = '0;
        pace_out.waited  = '0;
        if (ctrl.restart) begin
            first_frame_next = 1'b1;
            fast_acc_next    = '0;
            target_next      = fpbr_pkg::RESTART_INTERVAL;
        end else begin
            if (!first_frame_reg) begin
                if (rate >= {2'b00, target_reg}) begin
                    fast_acc_next = '0;
                    if (rate > {2'b00, target_reg} && target_reg < fpbr_pkg::MAX_INTERVAL) begin
                        target_next = target_reg + 3'd1;
                    end
                end else if (target_reg >= fpbr_pkg::SLOW_DOWN_MIN) begin
                    if (fast_sum >= fpbr_pkg::FAST_LIMIT) begin
                        fast_acc_next = '0;
                        target_next   = target_reg - 3'd1;
                    end else begin
                        fast_acc_next = fast_sum[5:0];
                    end
                end
            end
            if (lock) begin
                target_next = fpbr_pkg::LOCKED_INTERVAL;
            end
            waited_full = (rate > {2'b00, target_next}) ? rate : {2'b00, target_next};
            pace_out.waited = waited_full[4] ? fpbr_pkg::WAITED_MAX : waited_full[3:0];
            first_frame_next = 1'b0;
        end
        pace_out.target = target_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_frame_reg <= 1'b1;
            fast_acc_reg    <= '0;
            target_reg      <= fpbr_pkg::RESTART_INTERVAL;
        end else if (ctrl.step) begin
            first_frame_reg <= first_frame_next;
            fast_acc_reg    <= fast_acc_next;
            target_reg      <= target_next;
        end
    end

`ifndef SYNTHESIS
    // The target stays within one and the maximum interval.
    assert property (@(posedge aclk) disable iff (!aresetn)
        target_reg != 3'd0 && target_reg <= fpbr_pkg::MAX_INTERVAL)
        else $error("target interval out of range");

    // The fast vblank sum is cleared whenever it reaches the limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, fast_acc_reg} < fpbr_pkg::FAST_LIMIT)
        else $error("fast vblank accumulator at or above its limit");
`endif

endmodule

### hdl/frame_pacing_buffer_rotator.sv
// Top level of the frame pacing buffer rotator: stream ports, input and result registers.
//
// One input transaction is sent per rendered frame. The tuser bit selects the command
// (0 frame end, 1 restart); tdata carries the pending vblank count and the skip flag.
// For each input transaction exactly one result transaction follows, carrying the
// display, draw and next draw addresses, the target interval and the vblanks waited.
// The cfg channel writes the five registers by index; it is always ready and must be
// used only while no frame is in flight.
// An accepted item sits in the input register; when the result register is free or being
// taken, the ring and pacing logic load the result register from it.
// Throughput is one transaction per cycle while m_tready stays high; the pacing and ring
// state update in the same cycle that an item moves into the result register, so the next item sees it at once.
// When the receiver stalls, the result register holds and the input register keeps one
// more item, after which s_tready drops until m_tready returns.
// Reset (aresetn low at a clock edge) empties both registers, clears the configuration
// and restores the pacing state: first frame pending, interval two, ring at buffer zero.
module frame_pacing_buffer_rotator (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // [3:0] vblanks_pending, [4] skip_swap
    input  logic                              s_tuser,  // [0] command
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] display_address, [63:32] draw_address, [95:64] next_draw_address,
    // [98:96] target_interval, [102:99] vblanks_waited
    output logic [103:0]                      m_tdata,
    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fpbr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [31:0]                       cfg_data
);

    logic                     in_valid_reg;
    fpbr_pkg::fpbr_item_t     in_item_reg;
    logic                     m_valid_reg;
    logic [103:0]             m_data_reg;
    logic                     advance;
    fpbr_pkg::fpbr_ctrl_t     ctrl;
    fpbr_pkg::fpbr_cfg_t      cfg;
    fpbr_pkg::fpbr_ring_out_t ring_out;
    fpbr_pkg::fpbr_pace_out_t pace_out;

    // Pipeline handshake: an item moves on when the result register is free or being taken.
    assign advance   = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign ctrl.step    = advance;
    assign ctrl.restart = in_item_reg.command == fpbr_pkg::CMD_RESTART;
    assign ctrl.skip    = in_item_reg.skip;

    fpbr_cfg_regs u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .lock_clear (advance && ctrl.restart),
        .cfg        (cfg)
    );

    fpbr_ring u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .cfg      (cfg),
        .ring_out (ring_out)
    );

    fpbr_pace u_pace (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .pending  (in_item_reg.pending),
        .lock     (cfg.lock),
        .pace_out (pace_out)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.command <= s_tuser;
            in_item_reg.pending <= s_tdata[3:0];
            in_item_reg.skip    <= s_tdata[4];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= {1'b0, pace_out.waited, pace_out.target,
                           ring_out.next_draw, ring_out.draw, ring_out.display};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // A full input register facing a stalled result register blocks new input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && m_valid_reg && !m_tready |-> !s_tready)
        else $error("input accepted while both registers are held");

    // A restart yields interval two and no vblanks waited.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && ctrl.restart |=> m_tdata[98:96] == fpbr_pkg::RESTART_INTERVAL
                                    && m_tdata[102:99] == 4'd0)
        else $error("restart result carries wrong pacing fields");

    // Every item leaving the input register produces a valid result next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("result lost after an item left the input register");
`endif

endmodule
